>>> rtl/first_fit_allocator_with_compaction_macros.svh
// assertion macros for the first-fit allocator
// no dependencies; the asserting module must have clk and arst_n in scope
`ifndef FIRST_FIT_ALLOCATOR_WITH_COMPACTION_MACROS_SVH
`define FIRST_FIT_ALLOCATOR_WITH_COMPACTION_MACROS_SVH
`ifndef SYNTHESIS
`define FFAC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define FFAC_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define FFAC_ASSERT(lbl, prop, msg)
`define FFAC_NEVER(lbl, expr, msg)
`endif
`endif

>>> rtl/ffac_pkg.sv
// shared constants, codes and the result struct of the first-fit allocator
// no dependencies
package ffac_pkg;

	localparam int MEM_CELLS_DEF   = 128;
	localparam int HANDLE_BITS_DEF = 16;
	localparam logic [7:0] MEMSIZE_RST = 8'd128;

	localparam logic [1:0] CMD_ALLOC  = 2'd0;
	localparam logic [1:0] CMD_ERASE  = 2'd1;
	localparam logic [1:0] CMD_DEFRAG = 2'd2;

	localparam logic [1:0] ST_GRANT   = 2'd0;
	localparam logic [1:0] ST_NULL    = 2'd1;
	localparam logic [1:0] ST_ILLEGAL = 2'd2;

	typedef struct packed {
		logic        strobe;
		logic [1:0]  status;
		logic [15:0] handle;
	} res_t;

endpackage

>>> rtl/ffac_ram.sv
// owner table storage: one write port, one read port with registered data
// depends on nothing
module ffac_ram #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 16,
	parameter int AW    = 7
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/ffac_ctrl.sv
// command sequencer: clearing pass, table scans, block fill and compaction
// depends on ffac_pkg; drives the ports of ffac_ram
module ffac_ctrl #(
	parameter int MEM_CELLS   = ffac_pkg::MEM_CELLS_DEF,
	parameter int HANDLE_BITS = ffac_pkg::HANDLE_BITS_DEF,
	parameter int AW          = 7,
	parameter int CNT_W       = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [1:0]             cmd,
	input  logic [15:0]            value,
	input  logic [CNT_W-1:0]       usable,
	output logic                   busy,
	output ffac_pkg::res_t         res,
	output logic                   mem_we,
	output logic [AW-1:0]          mem_waddr,
	output logic [HANDLE_BITS-1:0] mem_wdata,
	output logic                   mem_re,
	output logic [AW-1:0]          mem_raddr,
	input  logic [HANDLE_BITS-1:0] mem_rdata
);
	import ffac_pkg::*;

	localparam logic [2:0] S_CLR   = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_AFILL = 3'd3;
	localparam logic [2:0] S_DFILL = 3'd4;

	localparam int CMP_W = (HANDLE_BITS > 16) ? HANDLE_BITS : 16;
	localparam int LEN_W = (CNT_W > 16) ? CNT_W : 16;
	localparam logic [CNT_W-1:0] LAST = CNT_W'(MEM_CELLS - 1);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(MEM_CELLS);

	logic [2:0]             state_q;
	logic [1:0]             op_q;
	logic [15:0]            arg_q;
	logic [CNT_W-1:0]       idx_q;
	logic [CNT_W-1:0]       end_q;
	logic [CNT_W-1:0]       run_q;
	logic [CNT_W-1:0]       ptr_q;
	logic [AW-1:0]          fill_end_q;
	logic                   found_q;
	logic [HANDLE_BITS-1:0] nh_q;
	logic                   vld_s1;
	logic [AW-1:0]          addr_s1;
	res_t                   res_q;

	logic             issue;
	logic             cell_free;
	logic [CNT_W-1:0] run_inc;
	logic             len_hit;
	logic             h_hit;
	logic             fill_go;

	assign busy      = (state_q != S_IDLE);
	assign res       = res_q;
	assign issue     = (state_q == S_SCAN) && (idx_q != end_q);
	assign mem_re    = issue;
	assign mem_raddr = idx_q[AW-1:0];
	assign cell_free = (mem_rdata == '0);
	assign run_inc   = run_q + CNT_W'(1);
	assign len_hit   = (LEN_W'(run_inc) == LEN_W'(arg_q));
	assign h_hit     = (CMP_W'(mem_rdata) == CMP_W'(arg_q));
	// free run long enough: stop the scan and fill the block
	assign fill_go   = vld_s1 && (op_q == CMD_ALLOC) && cell_free && len_hit;

	// write port: clear, erase hit, compaction move, block fill, tail clear
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = ptr_q[AW-1:0];
		mem_wdata = '0;
		unique case (state_q)
			S_CLR: begin
				mem_we = 1'b1;
			end
			S_SCAN: begin
				if (vld_s1 && op_q == CMD_ERASE && h_hit) begin
					mem_we    = 1'b1;
					mem_waddr = addr_s1;
				end else if (vld_s1 && op_q == CMD_DEFRAG && !cell_free) begin
					mem_we    = 1'b1;
					mem_wdata = mem_rdata;
				end
			end
			S_AFILL: begin
				mem_we    = 1'b1;
				mem_wdata = nh_q;
			end
			S_DFILL: begin
				mem_we = 1'b1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		res_t res_n;
		if (!arst_n) begin
			state_q <= S_CLR;
			ptr_q   <= '0;
			vld_s1  <= 1'b0;
			nh_q    <= HANDLE_BITS'(1);
			res_q   <= '0;
			found_q <= 1'b0;
			idx_q   <= '0;
			end_q   <= '0;
			run_q   <= '0;
			op_q    <= CMD_ALLOC;
		end else begin
			res_n = '0;
			unique case (state_q)
				S_CLR: begin
					ptr_q <= ptr_q + CNT_W'(1);
					if (ptr_q == LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						op_q    <= cmd;
						arg_q   <= value;
						idx_q   <= '0;
						vld_s1  <= 1'b0;
						run_q   <= '0;
						found_q <= 1'b0;
						ptr_q   <= '0;
						case (cmd)
							CMD_ALLOC: begin
								if (value == '0 || nh_q == '0 || usable == '0) begin
									res_n = '{strobe: 1'b1, status: ST_NULL, handle: '0};
								end else begin
									end_q   <= usable;
									state_q <= S_SCAN;
								end
							end
							CMD_ERASE: begin
								if (value == '0) begin
									res_n = '{strobe: 1'b1, status: ST_ILLEGAL, handle: '0};
								end else begin
									end_q   <= FULL;
									state_q <= S_SCAN;
								end
							end
							CMD_DEFRAG: begin
								end_q   <= FULL;
								state_q <= S_SCAN;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_SCAN: begin
					// one read issued per cycle, its data judged the cycle after
					if (issue) begin
						idx_q   <= idx_q + CNT_W'(1);
						addr_s1 <= idx_q[AW-1:0];
					end
					vld_s1 <= issue && !fill_go;
					if (vld_s1) begin
						case (op_q)
							CMD_ALLOC: begin
								if (!cell_free) begin
									run_q <= '0;
								end else if (len_hit) begin
									ptr_q      <= CNT_W'(addr_s1) - run_q;
									fill_end_q <= addr_s1;
									state_q    <= S_AFILL;
								end else begin
									run_q <= run_inc;
								end
							end
							CMD_ERASE: begin
								if (h_hit) begin
									found_q <= 1'b1;
								end
							end
							default: begin
								if (!cell_free) begin
									ptr_q <= ptr_q + CNT_W'(1);
								end
							end
						endcase
					end else if (!issue) begin
						case (op_q)
							CMD_ALLOC: begin
								res_n = '{strobe: 1'b1, status: ST_NULL, handle: '0};
								state_q <= S_IDLE;
							end
							CMD_ERASE: begin
								if (!found_q) begin
									res_n = '{strobe: 1'b1, status: ST_ILLEGAL, handle: '0};
								end
								state_q <= S_IDLE;
							end
							default: begin
								state_q <= (ptr_q == FULL) ? S_IDLE : S_DFILL;
							end
						endcase
					end
				end
				S_AFILL: begin
					ptr_q <= ptr_q + CNT_W'(1);
					if (ptr_q[AW-1:0] == fill_end_q) begin
						res_n = '{strobe: 1'b1, status: ST_GRANT, handle: 16'(nh_q)};
						nh_q    <= nh_q + HANDLE_BITS'(1);
						state_q <= S_IDLE;
					end
				end
				S_DFILL: begin
					ptr_q <= ptr_q + CNT_W'(1);
					if (ptr_q == LAST) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			res_q <= res_n;
		end
	end

endmodule

>>> rtl/first_fit_allocator_with_compaction.sv
// top level of the first-fit allocator with compaction
// depends on ffac_pkg, ffac_ctrl, ffac_ram and the assertion macro header
`include "first_fit_allocator_with_compaction_macros.svh"

// first-fit allocator over a table of MEM_CELLS owner entries held in one
// synchronous ram; each alloc, erase or defragment walks the table one cell
// per cycle through the ram's single read port, so the read port sets the rate.
// after reset a clearing pass writes MEM_CELLS zero entries with busy high;
// configuration writes are taken during it.
// what each item does, from acceptance to busy low:
//   alloc granted: scans the usable cells for the first free run of the
//     requested length, then fills that run with the next handle
//   alloc failed: scans the whole usable range (no scan when len is zero, the
//     handle counter is spent or no cell is usable)
//   erase: scans the whole table (no scan for handle zero)
//   defragment: scans the whole table, then clears the freed cells at the top
//   cmd 3: accepted and dropped, busy stays low
// a result sits on status/handle for one cycle, marked by done; the receiver
// cannot stall it, and a granted erase or a defragment gives no result
module first_fit_allocator_with_compaction #(
	parameter int MEM_CELLS   = ffac_pkg::MEM_CELLS_DEF,
	parameter int HANDLE_BITS = ffac_pkg::HANDLE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// command item
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [15:0] value,
	// result item
	output logic        done,
	output logic [1:0]  status,
	output logic [15:0] handle,
	// memory_size register write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);
	import ffac_pkg::*;

	localparam int AW    = (MEM_CELLS > 1) ? $clog2(MEM_CELLS) : 1;
	localparam int CNT_W = $clog2(MEM_CELLS + 1);
	localparam int LIM_W = (CNT_W > 8) ? CNT_W : 8;

	logic [7:0]             memsize_q;
	logic [LIM_W-1:0]       ms_ext;
	logic [CNT_W-1:0]       usable;
	res_t                   res;
	logic                   mem_we;
	logic [AW-1:0]          mem_waddr;
	logic [HANDLE_BITS-1:0] mem_wdata;
	logic                   mem_re;
	logic [AW-1:0]          mem_raddr;
	logic [HANDLE_BITS-1:0] mem_rdata;

	// register accepts any time; it is to be written only while the block is idle, which the block does not enforce
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			memsize_q <= MEMSIZE_RST;
		end else if (cfg_valid && cfg_ready) begin
			memsize_q <= cfg_data;
		end
	end

	// cells an alloc may search: memory_size capped at the table depth
	assign ms_ext = LIM_W'(memsize_q);
	assign usable = (ms_ext < LIM_W'(MEM_CELLS)) ? CNT_W'(ms_ext) : CNT_W'(MEM_CELLS);

	ffac_ctrl #(
		.MEM_CELLS   (MEM_CELLS),
		.HANDLE_BITS (HANDLE_BITS),
		.AW          (AW),
		.CNT_W       (CNT_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.value     (value),
		.usable    (usable),
		.busy      (busy),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// owner table, one handle per cell, 0 when free
	ffac_ram #(
		.DEPTH (MEM_CELLS),
		.WIDTH (HANDLE_BITS),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign done   = res.strobe;
	assign status = res.status;
	assign handle = res.handle;

	// a result follows either an accepted item or a running command
	`FFAC_ASSERT(a_done_cause, done |-> ($past(start && !busy) || $past(busy)), "stray result")
	// failures and illegal erases report handle zero
	`FFAC_ASSERT(a_fail_handle, (done && status != ST_GRANT) |-> (handle == '0), "bad fail handle")
	// busy only rises after an accepted item
	`FFAC_ASSERT(a_busy_rise, $rose(busy) |-> $past(start), "busy without item")
	// no result while a command is still walking the table
	`FFAC_NEVER(a_done_busy, done && busy, "result during command")

endmodule

>>> tb/testbench.sv
// self-checking testbench for the first-fit allocator with compaction
// depends on ffac_pkg and the first_fit_allocator_with_compaction rtl; reads no files
// directed table first, then random command phases over several memory_size settings
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ffac_pkg::*;

	localparam int MEM_CELLS = MEM_CELLS_DEF;
	// unknown command code, dropped by the block
	localparam logic [1:0] CMD_NONE = 2'd3;
	// longest busy stretch: a defragment that frees the whole table, plus slack
	localparam int SETTLE = 2 * MEM_CELLS + 16;
	// runaway limit on the cycle counter, with lots of room
	localparam int CYCLE_LIMIT = 3000000;
	localparam int PHASE_ITEMS = 190;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] handle;
	} reply_t;

	// one row of the directed table; typed rows carry the reply read off by hand
	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] arg;
		logic        typed;
		logic [1:0]  status;
		logic [15:0] handle;
	} plan_row_t;

	localparam int PLAN_ROWS = 23;
	localparam plan_row_t PLAN [PLAN_ROWS] = '{
		'{CMD_ALLOC,  16'd0,     1'b1, ST_NULL,    16'd0}, // zero length fails
		'{CMD_ALLOC,  16'hFFFF,  1'b1, ST_NULL,    16'd0}, // far too long
		'{CMD_ALLOC,  16'd129,   1'b1, ST_NULL,    16'd0}, // one past the table
		'{CMD_ALLOC,  16'd128,   1'b1, ST_GRANT,   16'd1}, // whole table
		'{CMD_ALLOC,  16'd1,     1'b1, ST_NULL,    16'd0}, // table full
		'{CMD_DEFRAG, 16'hFFFF,  1'b0, ST_GRANT,   16'd0}, // full table, nothing moves
		'{CMD_ERASE,  16'd0,     1'b1, ST_ILLEGAL, 16'd0}, // handle zero
		'{CMD_ERASE,  16'hFFFF,  1'b1, ST_ILLEGAL, 16'd0}, // never granted
		'{CMD_ERASE,  16'd1,     1'b0, ST_GRANT,   16'd0}, // frees everything
		'{CMD_ERASE,  16'd1,     1'b1, ST_ILLEGAL, 16'd0}, // already freed
		'{CMD_ALLOC,  16'd3,     1'b1, ST_GRANT,   16'd2},
		'{CMD_ALLOC,  16'd5,     1'b1, ST_GRANT,   16'd3},
		'{CMD_ALLOC,  16'd2,     1'b1, ST_GRANT,   16'd4},
		'{CMD_ERASE,  16'd3,     1'b0, ST_GRANT,   16'd0}, // opens a hole of five
		'{CMD_ALLOC,  16'd4,     1'b1, ST_GRANT,   16'd5}, // lands in the hole
		'{CMD_NONE,   16'hFFFF,  1'b0, ST_GRANT,   16'd0}, // dropped
		'{CMD_DEFRAG, 16'd0,     1'b0, ST_GRANT,   16'd0},
		'{CMD_ALLOC,  16'd1,     1'b0, ST_GRANT,   16'd0},
		'{CMD_ERASE,  16'd2,     1'b0, ST_GRANT,   16'd0},
		'{CMD_DEFRAG, 16'h5555,  1'b0, ST_GRANT,   16'd0},
		'{CMD_ALLOC,  16'd121,   1'b0, ST_GRANT,   16'd0}, // fills the rest
		'{CMD_ALLOC,  16'd1,     1'b0, ST_GRANT,   16'd0},
		'{CMD_ERASE,  16'd4,     1'b0, ST_GRANT,   16'd0}
	};

	localparam int PHASES = 8;
	// memory_size per random phase: extremes, oversize values and a few in between
	localparam logic [7:0] PHASE_SIZE [PHASES] = '{
		8'd1, 8'd0, 8'd255, 8'd128, 8'd9, 8'd64, 8'd129, 8'd40
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  cmd = CMD_ALLOC;
	logic [15:0] value = '0;
	logic        done;
	logic [1:0]  status;
	logic [15:0] handle;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data = '0;

	// private copy of the allocator state
	logic [15:0] owner_cells [MEM_CELLS];
	logic [15:0] next_grant;
	logic [7:0]  cell_count_cfg;

	reply_t pending_replies [$];
	int     errors = 0;
	int     cycles = 0;
	int     idle_pct = 32;

	first_fit_allocator_with_compaction dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.value     (value),
		.done      (done),
		.status    (status),
		.handle    (handle),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	// runaway guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d replies outstanding", $time, pending_replies.size());
			$display("Some tests failed");
			$finish;
		end
	end

	// work out the reply of one command and update the private state;
	// returns 1 when the command produces a reply
	function automatic bit apply_command(input logic [1:0] op, input logic [15:0] arg,
			output reply_t r);
		int  usable;
		int  run;
		int  dst;
		bit  hit;
		r.status = ST_NULL;
		r.handle = '0;
		hit = 1'b0;
		run = 0;
		dst = 0;
		case (op)
			CMD_ALLOC: begin
				// search stops at memory_size, capped at the table depth
				usable = (int'(cell_count_cfg) < MEM_CELLS) ? int'(cell_count_cfg) : MEM_CELLS;
				// zero length and a spent handle counter both fail outright
				if (arg == 16'd0 || next_grant == 16'd0)
					return 1'b1;
				for (int i = 0; i < usable; i++) begin
					if (owner_cells[i] != 16'd0) begin
						run = 0;
					end else begin
						run++;
						if (run == int'(arg)) begin
							for (int j = i + 1 - run; j <= i; j++)
								owner_cells[j] = next_grant;
							r.status = ST_GRANT;
							r.handle = next_grant;
							next_grant = next_grant + 16'd1;
							return 1'b1;
						end
					end
				end
				return 1'b1;
			end
			CMD_ERASE: begin
				// erase looks at the whole table, even above memory_size
				if (arg != 16'd0) begin
					for (int i = 0; i < MEM_CELLS; i++) begin
						if (owner_cells[i] == arg) begin
							owner_cells[i] = 16'd0;
							hit = 1'b1;
						end
					end
				end
				if (hit)
					return 1'b0;
				r.status = ST_ILLEGAL;
				return 1'b1;
			end
			CMD_DEFRAG: begin
				// slide owned cells down, keeping their order
				for (int i = 0; i < MEM_CELLS; i++) begin
					if (owner_cells[i] != 16'd0) begin
						owner_cells[dst] = owner_cells[i];
						dst++;
					end
				end
				for (int i = dst; i < MEM_CELLS; i++)
					owner_cells[i] = 16'd0;
				return 1'b0;
			end
			default: return 1'b0;
		endcase
	endfunction

	// handle of some live block, starting the search at a random cell
	function automatic logic [15:0] pick_live_handle();
		int base;
		base = $urandom_range(MEM_CELLS - 1);
		for (int k = 0; k < MEM_CELLS; k++) begin
			if (owner_cells[(base + k) % MEM_CELLS] != 16'd0)
				return owner_cells[(base + k) % MEM_CELLS];
		end
		return 16'($urandom_range(65535));
	endfunction

	// random command, weighted toward allocs that fit and erases of live blocks
	task automatic draw_command(output logic [1:0] op, output logic [15:0] arg);
		int pick;
		int usable;
		int cap;
		int r;
		pick = $urandom_range(99);
		usable = (int'(cell_count_cfg) < MEM_CELLS) ? int'(cell_count_cfg) : MEM_CELLS;
		cap = (usable == 0) ? 4 : ((usable < 12) ? usable : 12);
		r = $urandom_range(99);
		arg = 16'($urandom_range(65535));
		if (pick < 46) begin
			op = CMD_ALLOC;
			if (r < 80)
				arg = 16'($urandom_range(cap, 1));
			else if (r < 91)
				arg = 16'($urandom_range(usable + 2, 1));
			else if (r < 95)
				arg = 16'd0;
		end else if (pick < 76) begin
			op = CMD_ERASE;
			arg = pick_live_handle();
		end else if (pick < 85) begin
			// odd erase: zero, the not yet granted handle, any earlier one (live or stale) or noise
			op = CMD_ERASE;
			if (r < 25)
				arg = 16'd0;
			else if (r < 50)
				arg = next_grant;
			else if (r < 75 && next_grant > 16'd1)
				arg = 16'($urandom_range(int'(next_grant) - 1, 1));
		end else if (pick < 97) begin
			op = CMD_DEFRAG;
		end else begin
			op = CMD_NONE;
		end
	endtask

	// hand one command item to the block, with random idling or a full drain first
	task automatic issue(input logic [1:0] op, input logic [15:0] arg, input bit typed,
			input reply_t typed_reply);
		reply_t r;
		int     gap;
		if (idle_pct != 0 && $urandom_range(99) < 2) begin
			// hold off until every reply is back
			start <= 1'b0;
			do @(posedge clk); while (pending_replies.size() != 0);
		end else if ($urandom_range(99) < idle_pct) begin
			gap = ($urandom_range(3) == 0) ? $urandom_range(2 * MEM_CELLS + 4, 1)
				: $urandom_range(4, 1);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= op;
		value <= arg;
		do @(posedge clk); while (busy);
		if (apply_command(op, arg, r))
			pending_replies.push_back(typed ? typed_reply : r);
	endtask

	// memory_size write, only with the block quiet
	task automatic write_size(input logic [7:0] size);
		do @(posedge clk); while (pending_replies.size() != 0);
		// erase and defragment give no reply, so let any of them finish
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= size;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cell_count_cfg = size;
	endtask

	// reply checker: every done must match the oldest expectation
	always @(posedge clk) begin
		reply_t want;
		if (arst_n && done) begin
			if (pending_replies.size() == 0) begin
				$display("%0t: unexpected reply status %0d handle %0d", $time, status, handle);
				errors++;
			end else begin
				want = pending_replies.pop_front();
				if (status !== want.status) begin
					$display("%0t: status expected %0d got %0d", $time, want.status, status);
					errors++;
				end
				if (handle !== want.handle) begin
					$display("%0t: handle expected %0d got %0d", $time, want.handle, handle);
					errors++;
				end
			end
		end
	end

	initial begin
		logic [1:0]  op;
		logic [15:0] arg;
		reply_t      typed_reply;
		int          count;
		for (int i = 0; i < MEM_CELLS; i++)
			owner_cells[i] = 16'd0;
		next_grant = 16'd1;
		cell_count_cfg = MEMSIZE_RST;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed table at the reset size
		foreach (PLAN[i]) begin
			typed_reply.status = PLAN[i].status;
			typed_reply.handle = PLAN[i].handle;
			issue(PLAN[i].op, PLAN[i].arg, PLAN[i].typed, typed_reply);
		end

		// random phases; the table carries over, so lowering the size leaves
		// blocks above it for erase and defragment to find
		for (int p = 0; p < PHASES; p++) begin
			start <= 1'b0;
			write_size(PHASE_SIZE[p]);
			// one phase runs back to back with no idling
			idle_pct = (p == 3) ? 0 : 32;
			count = 0;
			while (count < PHASE_ITEMS) begin
				draw_command(op, arg);
				issue(op, arg, 1'b0, typed_reply);
				if (op != CMD_NONE)
					count++;
			end
		end

		start <= 1'b0;
		do @(posedge clk); while (pending_replies.size() != 0);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl
rtl/ffac_pkg.sv
rtl/ffac_ram.sv
rtl/ffac_ctrl.sv
rtl/first_fit_allocator_with_compaction.sv
tb/testbench.sv
